// ===== rtl/core/rrap_pkg.sv =====
`default_nettype none

package rrap_pkg;

    // Generator constants
    localparam logic [31:0] SEED_MIX   = 32'h4961_6E42;
    localparam int unsigned ROT_AMOUNT = 16;

    // Register map: word index decoded from paddr[2]
    localparam logic REG_SEED = 1'b0;

    // One word of work handed from front to back
    typedef struct packed {
        logic [31:0] range_low;
        logic [31:0] span;
        logic [31:0] word;
    } job_t;

    // Back end sequencer states
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_FIN
    } back_state_t;

    // Back end control strobes
    typedef struct packed {
        logic pop;
        logic step;
        logic load_out;
    } back_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/rrap_front.sv =====
`default_nettype none

module rrap_front
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              seed_wr,
    input  wire logic [31:0]       seed_data,
    output logic [31:0]            seed,
    input  wire logic [31:0]       range_low,
    input  wire logic [31:0]       range_high,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              q_full,
    output logic                   q_push,
    output rrap_pkg::job_t         q_job
);

    logic [31:0] seed_reg;
    logic [31:0] gen_high_reg;
    logic [31:0] gen_low_reg;
    logic [31:0] gen_high_next;
    logic [31:0] gen_low_next;
    logic [31:0] rot_word;

    // Rotate-add step of the generator
    always_comb
    begin
        rot_word      = (gen_high_reg << rrap_pkg::ROT_AMOUNT)
                      | (gen_high_reg >> (32 - rrap_pkg::ROT_AMOUNT));
        gen_high_next = rot_word + gen_low_reg;
        gen_low_next  = gen_low_reg + gen_high_next;
    end

    assign in_ready = ~q_full;
    assign q_push   = in_valid & ~q_full;
    assign seed     = seed_reg;

    // Classify the request: span of zero means full range
    always_comb
    begin
        q_job.range_low = range_low;
        q_job.span      = range_high - range_low + 32'd1;
        q_job.word      = gen_high_next;
    end

    // Seed and generator state; a seed write reloads both words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg     <= '0;
            gen_high_reg <= '0;
            gen_low_reg  <= rrap_pkg::SEED_MIX;
        end
        else if (seed_wr)
        begin
            seed_reg     <= seed_data;
            gen_high_reg <= seed_data;
            gen_low_reg  <= seed_data ^ rrap_pkg::SEED_MIX;
        end
        else if (q_push)
        begin
            gen_high_reg <= gen_high_next;
            gen_low_reg  <= gen_low_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/rrap_queue.sv =====
`default_nettype none

module rrap_queue
#(
    parameter int unsigned DEPTH = 2
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire rrap_pkg::job_t    push_job,
    output logic                   full,
    input  wire logic              pop,
    output logic                   not_empty,
    output rrap_pkg::job_t         head_job
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    rrap_pkg::job_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push & ~full;
    assign do_pop    = pop & not_empty;
    assign head_job  = mem[rd_ptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/rrap_back.sv =====
`default_nettype none

module rrap_back
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_not_empty,
    input  wire rrap_pkg::job_t    q_job,
    output logic                   q_pop,
    output logic [31:0]            value,
    output logic                   out_valid,
    input  wire logic              out_ready
);

    rrap_pkg::back_state_t state_reg;
    rrap_pkg::back_state_t state_next;
    rrap_pkg::back_ctrl_t  ctrl;

    logic [31:0] low_reg;
    logic [31:0] span_reg;
    logic [31:0] rem_reg;
    logic [31:0] dvd_reg;
    logic [4:0]  cnt_reg;
    logic [31:0] value_reg;
    logic        out_valid_reg;

    logic        out_free;
    logic [32:0] trial;
    logic [31:0] rem_step;

    assign out_free = ~out_valid_reg | out_ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rrap_pkg::BK_IDLE:
            begin
                if (q_not_empty)
                begin
                    state_next = (q_job.span == '0) ? rrap_pkg::BK_FIN : rrap_pkg::BK_DIV;
                end
            end
            rrap_pkg::BK_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = rrap_pkg::BK_FIN;
                end
            end
            rrap_pkg::BK_FIN:
            begin
                if (out_free)
                begin
                    state_next = rrap_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = rrap_pkg::BK_IDLE;
            end
        endcase
    end

    // Control strobes
    always_comb
    begin
        ctrl = '0;
        unique case (state_reg)
            rrap_pkg::BK_IDLE: ctrl.pop      = q_not_empty;
            rrap_pkg::BK_DIV:  ctrl.step     = 1'b1;
            rrap_pkg::BK_FIN:  ctrl.load_out = out_free;
            default:           ctrl          = '0;
        endcase
    end

    assign q_pop = ctrl.pop;

    // Restoring division, one quotient bit per cycle; only the remainder is kept
    always_comb
    begin
        trial = {rem_reg, dvd_reg[31]} - {1'b0, span_reg};
        if (trial[32])
        begin
            rem_step = {rem_reg[30:0], dvd_reg[31]};
        end
        else
        begin
            rem_step = trial[31:0];
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (ctrl.pop)
        begin
            low_reg  <= q_job.range_low;
            span_reg <= q_job.span;
            dvd_reg  <= q_job.word;
            cnt_reg  <= 5'd31;
            // full range: raw word goes straight through
            rem_reg  <= (q_job.span == '0) ? q_job.word : '0;
        end
        else if (ctrl.step)
        begin
            rem_reg <= rem_step;
            dvd_reg <= {dvd_reg[30:0], 1'b0};
            cnt_reg <= cnt_reg - 1'b1;
        end
        if (ctrl.load_out)
        begin
            value_reg <= low_reg + rem_reg;
        end
    end

    // State and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rrap_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (ctrl.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign value     = value_reg;
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ===== rtl/core/ranged_rotate_add_prng.sv =====
// An accepted word goes into the queue, is popped by the back end, is reduced by the
// bit-serial remainder unit, skipped for full range, and lands in the result register.
// The back end works on one word at a time: a pop, 32 divide steps, a result step.
// A short queue between front and back takes new words while a division runs.
// Reset (rst_n, async, active low): seed 0, generator words 0 and 0x49616E42,
// queue empty, no result pending.
`default_nettype none

module ranged_rotate_add_prng
#(
    parameter int unsigned QUEUE_DEPTH = 2
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic [31:0] range_low,
    input  wire logic [31:0] range_high,
    input  wire logic        in_valid,
    output logic             in_ready,
    output logic [31:0]      value,
    output logic             out_valid,
    input  wire logic        out_ready
);

    logic           seed_wr;
    logic [31:0]    seed;
    logic           q_full;
    logic           q_push;
    logic           q_pop;
    logic           q_not_empty;
    rrap_pkg::job_t push_job;
    rrap_pkg::job_t head_job;

    // Register access
    assign pready  = 1'b1;
    assign seed_wr = psel & penable & pwrite & (paddr[2] == rrap_pkg::REG_SEED);
    assign prdata  = (paddr[2] == rrap_pkg::REG_SEED) ? seed : '0;

    rrap_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .seed_wr    (seed_wr),
        .seed_data  (pwdata),
        .seed       (seed),
        .range_low  (range_low),
        .range_high (range_high),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_job      (push_job)
    );

    rrap_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_job  (push_job),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_job  (head_job)
    );

    rrap_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_job       (head_job),
        .q_pop       (q_pop),
        .value       (value),
        .out_valid   (out_valid),
        .out_ready   (out_ready)
    );

endmodule

`default_nettype wire

// ===== verif/prng_range_checker.sv =====
`timescale 1ns / 100ps

module prng_range_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,
    input  logic [31:0] range_low,
    input  logic [31:0] range_high,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [31:0] value,
    input  logic        out_valid,
    input  logic        out_ready,
    output int unsigned failures,
    output int unsigned outstanding
);

    localparam int unsigned REPORT_LIMIT = 10;

    // Shadow of the seed register and both generator words
    logic [31:0] seed_reg = '0;
    logic [31:0] gen_high = '0;
    logic [31:0] gen_low  = rrap_pkg::SEED_MIX;

    // Values still owed by the block, oldest first
    logic [31:0] expected_values[$];
    int unsigned fail_count = 0;

    // Count a mismatch; only the first REPORT_LIMIT are reported in full
    function automatic void flag(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display("%0t: %s: expected %h, got %h", $time, what, want, got);
    endfunction

    // Step the generator, then fold the new high word into the requested range.
    // A span that wraps to zero means the full 32-bit range: the raw word is added to lo.
    function automatic logic [31:0] draw_value(input logic [31:0] lo, input logic [31:0] hi);
        logic [31:0] span;
        logic [31:0] mixed;
        span     = hi - lo + 32'd1;
        mixed    = ((gen_high << rrap_pkg::ROT_AMOUNT)
                 | (gen_high >> (32 - rrap_pkg::ROT_AMOUNT))) + gen_low;
        gen_high = mixed;
        gen_low  = gen_low + mixed;
        return (span == '0) ? lo + mixed : lo + (mixed % span);
    endfunction

    always @(posedge clk)
    begin : track
        logic [31:0] want;
        if (!rst_n)
        begin
            seed_reg = '0;
            gen_high = '0;
            gen_low  = rrap_pkg::SEED_MIX;
            expected_values.delete();
        end
        else
        begin
            // Register port: a seed write reloads both words, other indexes are ignored
            if (psel && penable && pready && paddr[2] == rrap_pkg::REG_SEED)
            begin
                if (pwrite)
                begin
                    seed_reg = pwdata;
                    gen_high = pwdata;
                    gen_low  = pwdata ^ rrap_pkg::SEED_MIX;
                end
                else if (prdata !== seed_reg)
                    flag("seed readback", seed_reg, prdata);
            end

            // Result side: compare against the oldest owed value
            if (out_valid && out_ready)
            begin
                if (expected_values.size() == 0)
                    flag("value with none owed", 'x, value);
                else
                begin
                    want = expected_values.pop_front();
                    if (value !== want)
                        flag("value", want, value);
                end
            end

            // Request side
            if (in_valid && in_ready)
                expected_values.push_back(draw_value(range_low, range_high));
        end
        outstanding <= expected_values.size();
        failures    <= fail_count;
    end

endmodule

// ===== verif/ranged_rotate_add_prng_tb.sv =====
`timescale 1ns / 100ps

module ranged_rotate_add_prng_tb;

    localparam int unsigned RANDOM_PHASES   = 12;
    localparam int unsigned WORDS_PER_PHASE = 112;
    localparam int unsigned SETTLE_CYCLES   = 40;
    localparam int unsigned STALL_LIMIT     = 3000;
    localparam logic [2:0]  SEED_ADDR       = {rrap_pkg::REG_SEED, 2'b00};
    localparam logic [2:0]  SPARE_ADDR      = {~rrap_pkg::REG_SEED, 2'b00};

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        psel       = 1'b0;
    logic        penable    = 1'b0;
    logic        pwrite     = 1'b0;
    logic [2:0]  paddr      = '0;
    logic [31:0] pwdata     = '0;
    logic [31:0] prdata;
    logic        pready;
    logic [31:0] range_low  = '0;
    logic [31:0] range_high = '0;
    logic        in_valid   = 1'b0;
    logic        in_ready;
    logic [31:0] value;
    logic        out_valid;
    logic        out_ready  = 1'b0;

    // No idling on either side once set
    logic        calm       = 1'b0;
    logic        in_gaps    = 1'b1;
    int unsigned quiet_cycles = 0;
    int unsigned failures;
    int unsigned outstanding;

    always #1 clk = ~clk;

    ranged_rotate_add_prng dut (.*);

    prng_range_checker checker_i (.*);

    // Watchdog: too long without any word or register access moving
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
            quiet_cycles <= 0;
        else if (quiet_cycles + 1 >= STALL_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Result sink: ready in random stretches, broken by random stalls unless calm
    initial
    begin : sink
        @(posedge clk);
        forever
        begin
            if (!calm && $urandom_range(0, 2) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 60)) @(posedge clk);
        end
    end

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic read_reg(input logic [2:0] addr);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Present one request word, with an optional gap ahead of it, until taken
    task automatic offer_bounds(input logic [31:0] lo, input logic [31:0] hi);
        if (in_gaps && !calm && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        range_low  <= lo;
        range_high <= hi;
        do @(posedge clk); while (!in_ready);
    endtask

    // Bounds mix: free, narrow, full range, reversed, power-of-two and near-full spans
    task automatic random_bounds(output logic [31:0] lo, output logic [31:0] hi);
        int unsigned k;
        lo = $urandom();
        hi = $urandom();
        case ($urandom_range(0, 9))
            3, 4: hi = lo + $urandom_range(0, 255);
            5:
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    lo = '0;
                    hi = '1;
                end
                else
                    hi = lo - 32'd1;
            end
            6: lo = hi + $urandom_range(1, 1000);
            7:
            begin
                k  = $urandom_range(0, 31);
                hi = lo + (32'd1 << k) - 32'd1;
            end
            8: lo = '0;
            9:
            begin
                lo = $urandom_range(0, 15);
                hi = 32'hFFFF_FFFF - $urandom_range(0, 15);
            end
            default: ;
        endcase
    endtask

    // Let every owed value come back, then give the block time to settle
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin : stimulus
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] seed;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        read_reg(SEED_ADDR);

        // Corner bounds from the reset seed
        offer_bounds(32'h0000_0000, 32'h0000_0000);
        offer_bounds(32'h0000_0000, 32'hFFFF_FFFF);
        offer_bounds(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        offer_bounds(32'hFFFF_FFFF, 32'h0000_0000);
        offer_bounds(32'h0000_0001, 32'h0000_0000);
        offer_bounds(32'h8000_0000, 32'h7FFF_FFFF);
        offer_bounds(32'h0000_0000, 32'h0000_0001);
        offer_bounds(32'h0000_0000, 32'hFFFF_FFFE);
        offer_bounds(32'h0000_0001, 32'hFFFF_FFFF);
        offer_bounds(32'h0000_0005, 32'h0000_000A);
        offer_bounds(32'h0000_000A, 32'h0000_0005);
        offer_bounds(32'h1234_5678, 32'h1234_5678);
        offer_bounds(32'h7FFF_FFFF, 32'h8000_0000);
        offer_bounds(32'h0000_0000, 32'h7FFF_FFFF);
        offer_bounds(32'hFFFF_FFFE, 32'hFFFF_FFFF);
        offer_bounds(32'hAAAA_AAAA, 32'h5555_5555);
        offer_bounds(32'h5555_5555, 32'hAAAA_AAAA);
        offer_bounds(32'h0000_0000, 32'h0000_0002);
        offer_bounds(32'h0000_0000, 32'h0000_FFFF);
        drain();

        // Random phases, each from a fresh seed; the last one runs without idling
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0:       seed = 32'hFFFF_FFFF;
                1:       seed = 32'h0000_0000;
                2:       seed = rrap_pkg::SEED_MIX;
                3:       seed = 32'h8000_0000;
                4:       seed = 32'h0000_0001;
                default: seed = $urandom();
            endcase
            write_reg(SPARE_ADDR, $urandom());
            write_reg(SEED_ADDR, seed);
            read_reg(SEED_ADDR);
            calm    <= (p == RANDOM_PHASES - 1);
            in_gaps <= ($urandom_range(0, 3) != 0);
            for (int n = 0; n < WORDS_PER_PHASE; n++)
            begin
                random_bounds(lo, hi);
                offer_bounds(lo, hi);
            end
            drain();
        end

        if (failures == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
